// ===== rtl/tpm_pkg.sv =====
// Shared types, widths, codes and helpers for the touch point mapper.
package tpm_pkg;

  // Field and register widths.
  localparam int SAMPLE_BITS   = 12;
  localparam int COORD_BITS    = 12;
  localparam int CAL_BITS      = 12;
  localparam int RES_BITS      = 13;
  localparam int ORI_BITS      = 2;
  localparam int STS_BITS      = 2;
  localparam int REG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = RES_BITS;

  // Widths inside the scaling divider.
  localparam int QBITS     = RES_BITS;
  localparam int DVS_BITS  = CAL_BITS + 1;
  localparam int DIVD_BITS = QBITS + DVS_BITS;
  localparam int CMP_BITS  = (SAMPLE_BITS > CAL_BITS) ? SAMPLE_BITS : CAL_BITS;
  localparam int SAT_BITS  = QBITS + COORD_BITS;

  // Axis stage, product stage, then one stage per quotient bit.
  localparam int PIPE_STAGES = 2 + QBITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CAL_BITS-1:0]    cal_t;
  typedef logic [RES_BITS-1:0]    scr_t;
  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [QBITS-1:0]       quot_t;

  localparam coord_t COORD_MAX = '1;

  typedef enum logic [STS_BITS-1:0] {
    STS_OK      = 2'd0,
    STS_PEN_UP  = 2'd1,
    STS_BAD_CAL = 2'd2
  } sts_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW  = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_ORIENT = 3'd6
  } reg_idx_t;

  typedef enum logic [ORI_BITS-1:0] {
    ORI_MODE0  = 2'd0,
    ORI_MODE1  = 2'd1,
    ORI_MODE2  = 2'd2,
    ORI_LEGACY = 2'd3
  } ori_t;

  // Normalized position and window span of one axis.
  typedef struct packed {
    cal_t nrm;
    cal_t rng;
  } axis_t;

  // One result word.
  typedef struct packed {
    sts_t   status;
    coord_t pixel_x;
    coord_t pixel_y;
  } result_t;

  // Saturate a quotient to the largest screen coordinate.
  function automatic coord_t sat_coord(input quot_t q);
    logic [SAT_BITS-1:0] qw;
    qw = SAT_BITS'(q);
    if (qw > SAT_BITS'(COORD_MAX)) begin
      return COORD_MAX;
    end
    return qw[COORD_BITS-1:0];
  endfunction

endpackage

// ===== rtl/tpm_if.sv =====
// Channel interfaces of the touch point mapper: reading, result and configuration.
interface tpm_in_if;
  import tpm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t x_first;
  sample_t x_second;
  sample_t y_first;
  sample_t y_second;
  logic    pen_present;

  modport source(output valid, x_first, x_second, y_first, y_second, pen_present,
                 input ready);
  modport sink(input valid, x_first, x_second, y_first, y_second, pen_present,
               output ready);
endinterface

interface tpm_out_if;
  import tpm_pkg::*;
  logic   valid;
  logic   ready;
  sts_t   status;
  coord_t pixel_x;
  coord_t pixel_y;

  modport source(output valid, status, pixel_x, pixel_y, input ready);
  modport sink(input valid, status, pixel_x, pixel_y, output ready);
endinterface

interface tpm_cfg_if;
  import tpm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/tpm_axis.sv =====
// Axis lane: averages a sample pair, clamps it to the window and normalizes it.
module tpm_axis (
  input  tpm_pkg::sample_t first_i,
  input  tpm_pkg::sample_t second_i,
  input  tpm_pkg::cal_t    lo_i,
  input  tpm_pkg::cal_t    hi_i,
  output tpm_pkg::axis_t   axis_o
);
  import tpm_pkg::*;

  logic [SAMPLE_BITS:0] sum;
  logic [CMP_BITS-1:0]  avg;
  logic [CMP_BITS-1:0]  lo_w;
  logic [CMP_BITS-1:0]  hi_w;
  logic [CMP_BITS-1:0]  clip;
  logic [CMP_BITS-1:0]  ofs;

  // Average of the pair, then clamp low first and high second.
  always_comb begin
    sum  = {1'b0, first_i} + {1'b0, second_i};
    avg  = CMP_BITS'(sum[SAMPLE_BITS:1]);
    lo_w = CMP_BITS'(lo_i);
    hi_w = CMP_BITS'(hi_i);
    clip = (avg < lo_w) ? lo_w : avg;
    if (clip > hi_w) begin
      clip = hi_w;
    end
    ofs = clip - lo_w;
    axis_o.nrm = ofs[CAL_BITS-1:0];
    axis_o.rng = hi_i - lo_i;
  end

endmodule

// ===== rtl/tpm_scale.sv =====
// Scale lane: rounds num/den times span half up through a pipelined restoring divider.
module tpm_scale (
  input  logic           clk,
  input  logic           en,
  input  tpm_pkg::cal_t  num_i,
  input  tpm_pkg::cal_t  den_i,
  input  tpm_pkg::scr_t  span_i,
  output tpm_pkg::quot_t q_o
);
  import tpm_pkg::*;

  logic [DIVD_BITS-1:0] divd_nxt;
  logic [DIVD_BITS-1:0] divd_r;
  logic [DVS_BITS-1:0]  dvs_r;

  logic [DVS_BITS-1:0] rem_r [QBITS-1];
  logic [DVS_BITS-1:0] dvs_s_r [QBITS-1];
  quot_t               low_r [QBITS-1];
  quot_t               q_r [QBITS];

  // Dividend 2*num*span + den over divisor 2*den gives the half-up rounding.
  always_comb begin
    divd_nxt = DIVD_BITS'({num_i, 1'b0}) * DIVD_BITS'(span_i) + DIVD_BITS'(den_i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      divd_r <= divd_nxt;
      dvs_r  <= {den_i, 1'b0};
    end
  end

  // One quotient bit per stage, most significant first. The quotient never
  // exceeds the span, so the upper dividend bits start below the divisor.
  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [DVS_BITS-1:0] rem_in;
    logic [DVS_BITS-1:0] dvs_in;
    quot_t               low_in;
    quot_t               q_in;
    logic [DVS_BITS:0]   trial;
    logic [DVS_BITS:0]   diff;
    logic [DVS_BITS-1:0] rem_nxt;
    quot_t               low_nxt;
    quot_t               q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = divd_r[QBITS +: DVS_BITS];
      assign low_in = divd_r[QBITS-1:0];
      assign dvs_in = dvs_r;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign dvs_in = dvs_s_r[k-1];
      assign q_in   = q_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, low_in[QBITS-1]};
      diff    = trial - {1'b0, dvs_in};
      low_nxt = {low_in[QBITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_in}) begin
        rem_nxt = diff[DVS_BITS-1:0];
        q_nxt   = {q_in[QBITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_BITS-1:0];
        q_nxt   = {q_in[QBITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_nxt;
      end
    end

    if (k < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]   <= rem_nxt;
          low_r[k]   <= low_nxt;
          dvs_s_r[k] <= dvs_in;
        end
      end
    end
  end

  assign q_o = q_r[QBITS-1];

endmodule

// ===== rtl/touch_point_mapper_top.sv =====
// Top level of the touch point mapper: configuration, axis lanes, orientation merge, output.
//
// Usage:
//   in_ch carries one touch reading per word: two kept samples for each axis
//   and the pen-down level. out_ch returns one word per reading: a status
//   (point valid, pen up, calibration window invalid) and the pixel column
//   and row, both zero unless the status is point valid. cfg_ch writes the
//   calibration window, screen size and orientation; it is always ready. The user
//   must write it only while no reading is in flight; the block does not enforce this.
//   Throughput is one reading per cycle while the skid register is empty. A
//   result is registered in turn by the axis lanes at the accepting edge, the
//   scaling product register, one register per quotient bit (13) in the
//   pipelined divider of each scale lane, and the output register.
//   Reset empties the pipeline and restores the window to 0..4095 on both
//   axes, the screen to 320 by 240 and the orientation to 3.
//   When the receiver stalls, the pipeline moves one more word into a skid
//   register and then holds; in_ch.ready falls only while that register is
//   full, so ready never depends combinationally on out_ch.ready.
module touch_point_mapper_top (
  input logic        clk,
  input logic        rst_n,
  tpm_cfg_if.sink    cfg_ch,
  tpm_in_if.sink     in_ch,
  tpm_out_if.source  out_ch
);
  import tpm_pkg::*;

  // Configuration registers.
  cal_t x_lo_r;
  cal_t x_hi_r;
  cal_t y_lo_r;
  cal_t y_hi_r;
  scr_t scr_w_r;
  scr_t scr_h_r;
  ori_t ori_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lo_r  <= '0;
      x_hi_r  <= '1;
      y_lo_r  <= '0;
      y_hi_r  <= '1;
      scr_w_r <= RES_BITS'(320);
      scr_h_r <= RES_BITS'(240);
      ori_r   <= ORI_LEGACY;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_X_LOW:  x_lo_r  <= cfg_ch.data[CAL_BITS-1:0];
        REG_X_HIGH: x_hi_r  <= cfg_ch.data[CAL_BITS-1:0];
        REG_Y_LOW:  y_lo_r  <= cfg_ch.data[CAL_BITS-1:0];
        REG_Y_HIGH: y_hi_r  <= cfg_ch.data[CAL_BITS-1:0];
        REG_WIDTH:  scr_w_r <= cfg_ch.data[RES_BITS-1:0];
        REG_HEIGHT: scr_h_r <= cfg_ch.data[RES_BITS-1:0];
        REG_ORIENT: ori_r   <= ori_t'(cfg_ch.data[ORI_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid register is empty.
  logic skid_v_r;
  logic en;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // Axis lanes on the incoming word.
  axis_t ax;
  axis_t ay;
  sts_t  sts0_nxt;

  tpm_axis u_axis_x (
    .first_i  (in_ch.x_first),
    .second_i (in_ch.x_second),
    .lo_i     (x_lo_r),
    .hi_i     (x_hi_r),
    .axis_o   (ax)
  );

  tpm_axis u_axis_y (
    .first_i  (in_ch.y_first),
    .second_i (in_ch.y_second),
    .lo_i     (y_lo_r),
    .hi_i     (y_hi_r),
    .axis_o   (ay)
  );

  // Pen up takes priority over a bad calibration window.
  always_comb begin
    if (!in_ch.pen_present) begin
      sts0_nxt = STS_PEN_UP;
    end else if (x_lo_r >= x_hi_r || y_lo_r >= y_hi_r) begin
      sts0_nxt = STS_BAD_CAL;
    end else begin
      sts0_nxt = STS_OK;
    end
  end

  // Valid bits, status and axis results travel down the pipeline.
  logic [PIPE_STAGES-1:0] vld_r;
  sts_t                   sts_r [PIPE_STAGES];
  axis_t                  ax_r;
  axis_t                  ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_STAGES-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r     <= ax;
      ay_r     <= ay;
      sts_r[0] <= sts0_nxt;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        sts_r[k] <= sts_r[k-1];
      end
    end
  end

  // Orientation merge: pick the fraction that feeds each screen axis.
  cal_t un;
  cal_t ud;
  cal_t vn;
  cal_t vd;

  always_comb begin
    case (ori_r)
      ORI_LEGACY: begin
        un = ay_r.nrm;              ud = ay_r.rng;
        vn = ax_r.nrm;              vd = ax_r.rng;
      end
      ORI_MODE0: begin
        un = ax_r.rng - ax_r.nrm;   ud = ax_r.rng;
        vn = ay_r.nrm;              vd = ay_r.rng;
      end
      ORI_MODE1: begin
        un = ay_r.rng - ay_r.nrm;   ud = ay_r.rng;
        vn = ax_r.rng - ax_r.nrm;   vd = ax_r.rng;
      end
      default: begin
        un = ax_r.nrm;              ud = ax_r.rng;
        vn = ay_r.rng - ay_r.nrm;   vd = ay_r.rng;
      end
    endcase
  end

  // Resolution minus one; a zero resolution acts as one.
  scr_t span_x;
  scr_t span_y;

  assign span_x = (scr_w_r == '0) ? '0 : RES_BITS'(scr_w_r - 1'b1);
  assign span_y = (scr_h_r == '0) ? '0 : RES_BITS'(scr_h_r - 1'b1);

  // Scale lanes, one per screen axis.
  quot_t qx;
  quot_t qy;

  tpm_scale u_scale_x (
    .clk    (clk),
    .en     (en),
    .num_i  (un),
    .den_i  (ud),
    .span_i (span_x),
    .q_o    (qx)
  );

  tpm_scale u_scale_y (
    .clk    (clk),
    .en     (en),
    .num_i  (vn),
    .den_i  (vd),
    .span_i (span_y),
    .q_o    (qy)
  );

  // Result word from the last stage; pixels are zero unless the point is valid.
  result_t res_nxt;
  logic    pipe_out_v;

  always_comb begin
    res_nxt.status = sts_r[PIPE_STAGES-1];
    if (sts_r[PIPE_STAGES-1] == STS_OK) begin
      res_nxt.pixel_x = sat_coord(qx);
      res_nxt.pixel_y = sat_coord(qy);
    end else begin
      res_nxt.pixel_x = '0;
      res_nxt.pixel_y = '0;
    end
  end

  assign pipe_out_v = en && vld_r[PIPE_STAGES-1];

  // Output register with a skid register behind it.
  result_t out_r;
  result_t skid_r;
  logic    out_v_r;
  logic    take;

  assign take = out_ch.ready || !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= pipe_out_v;
      end
    end else if (pipe_out_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (pipe_out_v) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.status  = out_r.status;
  assign out_ch.pixel_x = out_r.pixel_x;
  assign out_ch.pixel_y = out_r.pixel_y;

`ifndef SYNTHESIS
  // A word waits in the skid register only behind a word on the output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a word while the output is empty");

  // Pen up and bad calibration results carry zero pixels.
  a_status_zero_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status != STS_OK |-> out_r.pixel_x == '0 && out_r.pixel_y == '0)
    else $error("non-valid status with nonzero pixel");

  // The pipeline freezes while the skid register is full.
  a_freeze_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(vld_r))
    else $error("pipeline moved while the skid register was full");
`endif

endmodule
